// File: design/rgb_to_hsv_converter_core_macros.svh
// assertion macros shared by the checker
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RGBHSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbhsv check failed");

// next-cycle implication, disabled while in reset
`define RGBHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbhsv check failed");

`endif

// File: design/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int CH_W           = 8;
    localparam int HUE_W          = 15;
    localparam int SAT_W          = 13;
    localparam int HUE_FRAC       = 6;
    localparam int SAT_FRAC       = 12;
    localparam int QUOT_W         = 15;
    localparam int DVD_W          = QUOT_W + CH_W;
    localparam int BITS_PER_STAGE = 3;
    localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
    localparam int NUM_W          = 19;

    localparam logic signed [NUM_W-1:0] DEG_60  = NUM_W'(60);
    localparam logic signed [NUM_W-1:0] DEG_120 = NUM_W'(120);
    localparam logic signed [NUM_W-1:0] DEG_240 = NUM_W'(240);
    localparam logic signed [NUM_W-1:0] DEG_360 = NUM_W'(360);

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        sector_t                sector;
        logic signed [CH_W:0]   diff;
        logic [CH_W-1:0]        mx;
        logic [CH_W-1:0]        delta;
    } sort_item_t;

    // remainder in the top CH_W bits, dividend bits turning into quotient below
    typedef struct packed {
        logic [DVD_W-1:0] hue_w;
        logic [CH_W-1:0]  hue_d;
        logic [DVD_W-1:0] sat_w;
        logic [CH_W-1:0]  sat_d;
        logic [CH_W-1:0]  val;
    } div_item_t;

    // one restoring division step
    function automatic logic [DVD_W-1:0] div_step(input logic [DVD_W-1:0] w,
                                                  input logic [CH_W-1:0] d);
        logic [CH_W:0] t;
        logic [CH_W:0] rem;
        t   = w[DVD_W-1:QUOT_W-1];
        rem = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            div_step = {rem[CH_W-1:0], w[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            div_step = {t[CH_W-1:0], w[QUOT_W-2:0], 1'b0};
        end
    endfunction

endpackage

// File: design/rgb_to_hsv_converter_core.sv
// rgb to hsv converter, one 8-bit rgb pixel in, one hsv result out
// pixel channel: pixel_valid/pixel_ready carry red, green and blue;
//   a transaction happens when both are high at a rising edge of clk
// hsv channel: hsv_valid/hsv_ready carry hue (degrees, 6 fraction bits),
//   saturation (12 fraction bits, 4096 is one) and brightness (channel max)
// pipeline: seven register stages, the first loaded at the pixel transaction
//   edge - one stage for max/min and sector, one for the hue numerator, five
//   for the two pipelined restoring dividers at three quotient bits per
//   stage
// throughput: one pixel per cycle while hsv_ready is high, set by the divider stages
// each stage holds its own valid bit and advances when the stage after it
//   is empty or moving, so bubbles close up
// a stalled receiver holds the last stage; earlier stages keep filling and
//   pixel_ready falls only once all seven stages are full
// reset (rst_n low, asynchronous) clears every valid bit; nothing else is
//   kept between pixels
module rgb_to_hsv_converter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]     red,
    input  logic [rgbhsv_pkg::CH_W-1:0]     green,
    input  logic [rgbhsv_pkg::CH_W-1:0]     blue,
    output logic                            hsv_valid,
    input  logic                            hsv_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]    hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]    saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]     brightness
);

    logic                       sort_valid;
    logic                       sort_ready;
    rgbhsv_pkg::sort_item_t     sort_item;
    logic                       num_valid;
    logic                       num_ready;
    rgbhsv_pkg::div_item_t      num_item;

    rgbhsv_sort u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (sort_valid),
        .out_ready (sort_ready),
        .out_item  (sort_item)
    );

    rgbhsv_num u_num (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sort_valid),
        .in_ready  (sort_ready),
        .in_item   (sort_item),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_item  (num_item)
    );

    rgbhsv_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (num_valid),
        .in_ready   (num_ready),
        .in_item    (num_item),
        .out_valid  (hsv_valid),
        .out_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

// File: design/rgbhsv_sort.sv
module rgbhsv_sort (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]   red,
    input  logic [rgbhsv_pkg::CH_W-1:0]   green,
    input  logic [rgbhsv_pkg::CH_W-1:0]   blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rgbhsv_pkg::sort_item_t        out_item
);

    logic                   valid_reg;
    rgbhsv_pkg::sort_item_t item_reg;
    rgbhsv_pkg::sort_item_t item_next;
    logic [rgbhsv_pkg::CH_W-1:0] mn;
    logic                   load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        // tie order: red, then green, then blue
        if (red >= green && red >= blue)
        begin
            item_next.sector = rgbhsv_pkg::SECT_RED;
            item_next.mx     = red;
            item_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            item_next.sector = rgbhsv_pkg::SECT_GREEN;
            item_next.mx     = green;
            item_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            item_next.sector = rgbhsv_pkg::SECT_BLUE;
            item_next.mx     = blue;
            item_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        item_next.delta = item_next.mx - mn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: design/rgbhsv_num.sv
module rgbhsv_num (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rgbhsv_pkg::sort_item_t  in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rgbhsv_pkg::div_item_t   out_item
);

    logic                                   valid_reg;
    rgbhsv_pkg::div_item_t                  item_reg;
    rgbhsv_pkg::div_item_t                  item_next;
    logic signed [rgbhsv_pkg::NUM_W-1:0]    diff_x;
    logic signed [rgbhsv_pkg::NUM_W-1:0]    delta_x;
    logic signed [rgbhsv_pkg::NUM_W-1:0]    num;
    logic                                   load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign diff_x  = rgbhsv_pkg::NUM_W'(in_item.diff);
    assign delta_x = $signed(rgbhsv_pkg::NUM_W'(in_item.delta));

    // hue numerator: degrees times delta
    always_comb
    begin
        case (in_item.sector)
            rgbhsv_pkg::SECT_RED:
            begin
                num = diff_x * rgbhsv_pkg::DEG_60;
                if (num < 0)
                begin
                    num = num + delta_x * rgbhsv_pkg::DEG_360;
                end
            end
            rgbhsv_pkg::SECT_GREEN:
            begin
                num = delta_x * rgbhsv_pkg::DEG_120 + diff_x * rgbhsv_pkg::DEG_60;
            end
            rgbhsv_pkg::SECT_BLUE:
            begin
                num = delta_x * rgbhsv_pkg::DEG_240 + diff_x * rgbhsv_pkg::DEG_60;
            end
            default:
            begin
                num = '0;
            end
        endcase
    end

    // zero divisors become one, their dividends are already zero
    always_comb
    begin
        item_next.hue_w = rgbhsv_pkg::DVD_W'({num, {rgbhsv_pkg::HUE_FRAC{1'b0}}});
        item_next.hue_d = (in_item.delta == '0) ? rgbhsv_pkg::CH_W'(1) : in_item.delta;
        item_next.sat_w = rgbhsv_pkg::DVD_W'({in_item.delta, {rgbhsv_pkg::SAT_FRAC{1'b0}}});
        item_next.sat_d = (in_item.mx == '0) ? rgbhsv_pkg::CH_W'(1) : in_item.mx;
        item_next.val   = in_item.mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: design/rgbhsv_div.sv
module rgbhsv_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rgbhsv_pkg::div_item_t           in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]    hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]    saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]     brightness
);

    localparam int LAST = rgbhsv_pkg::DIV_STAGES - 1;

    logic [rgbhsv_pkg::DIV_STAGES-1:0]  valid_reg;
    logic [rgbhsv_pkg::DIV_STAGES-1:0]  stage_ready;
    rgbhsv_pkg::div_item_t              data_reg [rgbhsv_pkg::DIV_STAGES];

    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[LAST];
    assign hue        = data_reg[LAST].hue_w[rgbhsv_pkg::HUE_W-1:0];
    assign saturation = data_reg[LAST].sat_w[rgbhsv_pkg::SAT_W-1:0];
    assign brightness = data_reg[LAST].val;

    for (genvar s = 0; s < rgbhsv_pkg::DIV_STAGES; s++)
    begin : g_stage
        rgbhsv_pkg::div_item_t  stage_in;
        rgbhsv_pkg::div_item_t  data_next;
        logic                   stage_in_valid;
        logic                   down_ready;

        if (s == 0)
        begin : g_first
            assign stage_in       = in_item;
            assign stage_in_valid = in_valid;
        end
        else
        begin : g_mid
            assign stage_in       = data_reg[s-1];
            assign stage_in_valid = valid_reg[s-1];
        end

        if (s == LAST)
        begin : g_tail
            assign down_ready = out_ready;
        end
        else
        begin : g_body
            assign down_ready = stage_ready[s+1];
        end

        assign stage_ready[s] = !valid_reg[s] || down_ready;

        // three quotient bits (BITS_PER_STAGE) per stage for both lanes
        always_comb
        begin
            data_next = stage_in;
            for (int b = 0; b < rgbhsv_pkg::BITS_PER_STAGE; b++)
            begin
                data_next.hue_w = rgbhsv_pkg::div_step(data_next.hue_w, data_next.hue_d);
                data_next.sat_w = rgbhsv_pkg::div_step(data_next.sat_w, data_next.sat_d);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= stage_in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && stage_in_valid)
            begin
                data_reg[s] <= data_next;
            end
        end
    end

endmodule

// File: design/rgbhsv_check.sv
`include "rgb_to_hsv_converter_core_macros.svh"

module rgbhsv_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pixel_valid,
    input logic                            pixel_ready,
    input logic [rgbhsv_pkg::CH_W-1:0]     red,
    input logic [rgbhsv_pkg::CH_W-1:0]     green,
    input logic [rgbhsv_pkg::CH_W-1:0]     blue,
    input logic                            hsv_valid,
    input logic                            hsv_ready,
    input logic [rgbhsv_pkg::HUE_W-1:0]    hue,
    input logic [rgbhsv_pkg::SAT_W-1:0]    saturation,
    input logic [rgbhsv_pkg::CH_W-1:0]     brightness
);

    // stalled result holds
    `RGBHSV_ASSERT_NEXT(a_hold, clk, rst_n, hsv_valid && !hsv_ready, hsv_valid && $stable(hue) && $stable(saturation) && $stable(brightness))

    // black pixel has no saturation
    `RGBHSV_ASSERT_SAME(a_black, clk, rst_n, hsv_valid && brightness == '0, saturation == '0)

    // grey pixel has no hue
    `RGBHSV_ASSERT_SAME(a_grey, clk, rst_n, hsv_valid && saturation == '0, hue == '0)

    // results stay in range
    `RGBHSV_ASSERT_SAME(a_range, clk, rst_n, hsv_valid, saturation <= 13'd4096 && hue < 15'd23040)

endmodule

bind rgb_to_hsv_converter_core rgbhsv_check u_check (.*);

// File: tb/tb_top.sv
module tb_top;

    localparam int PIXEL_COUNT = 400;
    localparam int CALM_TAIL   = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;
    localparam int SHOWN_ERRS  = 10;

    typedef struct packed {
        logic [rgbhsv_pkg::HUE_W-1:0] hue;
        logic [rgbhsv_pkg::SAT_W-1:0] sat;
        logic [rgbhsv_pkg::CH_W-1:0]  val;
    } hsv_t;

    class hsv_tracker;
        hsv_t hsv_due[$];
        int   mismatches;
        int   pixels_in;
        int   hsv_seen;
        int   gray_seen;
        int   per_sector[3];

        function hsv_t hsv_of(logic [rgbhsv_pkg::CH_W-1:0] r, logic [rgbhsv_pkg::CH_W-1:0] g,
                              logic [rgbhsv_pkg::CH_W-1:0] b);
            int                  mx;
            int                  mn;
            int                  delta;
            int                  num;
            rgbhsv_pkg::sector_t sect;
            hsv_t                res;
            mx    = (r > g) ? r : g;
            mx    = (mx > b) ? mx : b;
            mn    = (r < g) ? r : g;
            mn    = (mn < b) ? mn : b;
            delta = mx - mn;
            res.val = rgbhsv_pkg::CH_W'(mx);
            res.sat = (mx == 0) ? '0 :
                      rgbhsv_pkg::SAT_W'((delta << rgbhsv_pkg::SAT_FRAC) / mx);
            res.hue = '0;
            if (delta == 0)
            begin
                gray_seen++;
            end
            else
            begin
                // red wins ties, then green
                if (r == mx)
                begin
                    sect = rgbhsv_pkg::SECT_RED;
                    num  = 60 * (int'(g) - int'(b));
                    if (num < 0)
                    begin
                        num += 360 * delta;
                    end
                end
                else if (g == mx)
                begin
                    sect = rgbhsv_pkg::SECT_GREEN;
                    num  = 120 * delta + 60 * (int'(b) - int'(r));
                end
                else
                begin
                    sect = rgbhsv_pkg::SECT_BLUE;
                    num  = 240 * delta + 60 * (int'(r) - int'(g));
                end
                per_sector[sect]++;
                res.hue = rgbhsv_pkg::HUE_W'((num << rgbhsv_pkg::HUE_FRAC) / delta);
            end
            return res;
        endfunction

        function void note_pixel(logic [rgbhsv_pkg::CH_W-1:0] r,
                                 logic [rgbhsv_pkg::CH_W-1:0] g,
                                 logic [rgbhsv_pkg::CH_W-1:0] b);
            hsv_due.push_back(hsv_of(r, g, b));
            pixels_in++;
        endfunction

        function void check_hsv(logic [rgbhsv_pkg::HUE_W-1:0] h,
                                logic [rgbhsv_pkg::SAT_W-1:0] s,
                                logic [rgbhsv_pkg::CH_W-1:0] v);
            hsv_t want;
            hsv_seen++;
            if (hsv_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRS)
                begin
                    $display("unexpected hsv transaction: hue %0d sat %0d val %0d", h, s, v);
                end
                return;
            end
            want = hsv_due.pop_front();
            if (h !== want.hue || s !== want.sat || v !== want.val)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRS)
                begin
                    $display("hsv mismatch: expected hue %0d sat %0d val %0d,",
                             want.hue, want.sat, want.val,
                             " got hue %0d sat %0d val %0d", h, s, v);
                end
            end
        endfunction

        function int pending();
            return hsv_due.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         pixel_valid;
    logic                         pixel_ready;
    logic [rgbhsv_pkg::CH_W-1:0]  red;
    logic [rgbhsv_pkg::CH_W-1:0]  green;
    logic [rgbhsv_pkg::CH_W-1:0]  blue;
    logic                         hsv_valid;
    logic                         hsv_ready;
    logic [rgbhsv_pkg::HUE_W-1:0] hue;
    logic [rgbhsv_pkg::SAT_W-1:0] saturation;
    logic [rgbhsv_pkg::CH_W-1:0]  brightness;

    hsv_tracker tracker;
    bit         calm;
    int         cycles;

    rgb_to_hsv_converter_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hsv_valid   (hsv_valid),
        .hsv_ready   (hsv_ready),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                tracker.note_pixel(red, green, blue);
            end
            if (hsv_valid && hsv_ready)
            begin
                tracker.check_hsv(hue, saturation, brightness);
            end
        end
    end

    // receiver side with random stall bursts
    initial
    begin
        hsv_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 7) != 0)
            begin
                hsv_ready = 1'b1;
            end
            else
            begin
                hsv_ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [rgbhsv_pkg::CH_W-1:0] r,
                              input logic [rgbhsv_pkg::CH_W-1:0] g,
                              input logic [rgbhsv_pkg::CH_W-1:0] b);
        @(negedge clk);
        pixel_valid = 1'b1;
        red         = r;
        green       = g;
        blue        = b;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
    endtask

    task automatic pixel_gap(input int n);
        @(negedge clk);
        pixel_valid = 1'b0;
        red         = rgbhsv_pkg::CH_W'($urandom);
        green       = rgbhsv_pkg::CH_W'($urandom);
        blue        = rgbhsv_pkg::CH_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(negedge clk);
    endtask

    task automatic random_pixel();
        logic [rgbhsv_pkg::CH_W-1:0] a;
        logic [rgbhsv_pkg::CH_W-1:0] c;
        logic [rgbhsv_pkg::CH_W-1:0] d;
        a = rgbhsv_pkg::CH_W'($urandom);
        c = rgbhsv_pkg::CH_W'($urandom);
        d = rgbhsv_pkg::CH_W'($urandom);
        case ($urandom_range(0, 9))
            0: send_pixel(a, a, a);
            1:
            begin
                // two channels share the maximum
                if (c > a)
                begin
                    a = c;
                end
                case ($urandom_range(0, 2))
                    0: send_pixel(a, a, c);
                    1: send_pixel(c, a, a);
                    default: send_pixel(a, c, a);
                endcase
            end
            2: send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00, c,
                          $urandom_range(0, 1) ? 8'hff : 8'h00);
            3: send_pixel(a, rgbhsv_pkg::CH_W'($urandom_range(0, 3)),
                          rgbhsv_pkg::CH_W'($urandom_range(0, 3)));
            default: send_pixel(a, c, d);
        endcase
    endtask

    initial
    begin
        tracker     = new();
        calm        = 1'b0;
        cycles      = 0;
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        red         = '0;
        green       = '0;
        blue        = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd85,  8'd170, 8'd255);

        for (int i = 0; i < PIXEL_COUNT; i++)
        begin
            if (i == PIXEL_COUNT / 2)
            begin
                pixel_gap(1);
                wait_drained();
            end
            calm = (i >= PIXEL_COUNT - CALM_TAIL) || (i >= 100 && i < 140);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                pixel_gap($urandom_range(1, 17));
            end
            random_pixel();
        end
        pixel_gap(1);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("%0d pixels in, %0d results checked: %0d gray, sectors r/g/b %0d/%0d/%0d",
                 tracker.pixels_in, tracker.hsv_seen, tracker.gray_seen,
                 tracker.per_sector[rgbhsv_pkg::SECT_RED],
                 tracker.per_sector[rgbhsv_pkg::SECT_GREEN],
                 tracker.per_sector[rgbhsv_pkg::SECT_BLUE]);
        $display("%0d mismatches, %0d results outstanding", tracker.mismatches,
                 tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/rgbhsv_pkg.sv
design/rgbhsv_sort.sv
design/rgbhsv_num.sv
design/rgbhsv_div.sv
design/rgb_to_hsv_converter_core.sv
design/rgbhsv_check.sv
tb/tb_top.sv
